// ===== hw/rtl/dam_pkg.sv =====
// Package: shared types, codes and helpers for the decimal accumulator machine.
package dam_pkg;

	localparam int MEM_WORDS_DEF = 100;
	localparam int WORD_W = 32;
	localparam int STEP_W = 16;
	localparam logic [STEP_W-1:0] MAX_STEPS_RST = 16'd100;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EXEC = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0,
		ST_HALT = 3'd1,
		ST_DIV0 = 3'd2,
		ST_BADOP = 3'd3,
		ST_LIMIT = 3'd4,
		ST_OVER = 3'd5
	} status_t;

	localparam logic [6:0] OPC_READ = 7'd10;
	localparam logic [6:0] OPC_WRITE = 7'd11;
	localparam logic [6:0] OPC_LOAD = 7'd20;
	localparam logic [6:0] OPC_STORE = 7'd21;
	localparam logic [6:0] OPC_ADD = 7'd30;
	localparam logic [6:0] OPC_SUB = 7'd31;
	localparam logic [6:0] OPC_DIV = 7'd32;
	localparam logic [6:0] OPC_MUL = 7'd33;
	localparam logic [6:0] OPC_BR = 7'd40;
	localparam logic [6:0] OPC_BRNEG = 7'd41;
	localparam logic [6:0] OPC_BRZERO = 7'd42;
	localparam logic [6:0] OPC_HALT = 7'd43;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_FETCH,
		CS_DECODE,
		CS_SPLIT,
		CS_OPERAND,
		CS_EXEC,
		CS_DIV,
		CS_DIVFIX,
		CS_RESULT
	} cstate_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;
		logic mem_load;
		logic restart;
		logic fetch;
		logic decode;
		logic split;
		logic operand;
		logic exec;
		logic div_start;
		logic div_step;
		logic div_done;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic stop_pre;
		logic is_div;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== hw/rtl/dam_if.sv =====
// Interfaces: input item, result item and configuration write channels.
interface dam_in_if;
	import dam_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [6:0] address;
	logic signed [31:0] word;
	modport source (output valid, op, address, word, input ready);
	modport sink (input valid, op, address, word, output ready);
endinterface

interface dam_out_if;
	logic valid;
	logic ready;
	logic [6:0] pc;
	logic signed [31:0] acc_value;
	logic out_valid;
	logic signed [31:0] out_value;
	logic read_used;
	logic [2:0] status;
	modport source (output valid, pc, acc_value, out_valid, out_value, read_used, status,
		input ready);
	modport sink (input valid, pc, acc_value, out_valid, out_value, read_used, status,
		output ready);
endinterface

interface dam_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/decimal_accumulator_machine.sv =====
// Top level: decimal accumulator machine with handshaked input, result and config.
// One result per item. A load, restart or the unused op goes through the execute and
// result states; an instruction goes through fetch, decode, split, operand read from the
// single-port word memory, execute and result, and a stopped machine skips from decode
// to result. A divide adds 32 one-bit steps of the restoring divider and a sign fix
// before the result. Items are taken one at a time; the next is accepted once the
// result sits in the output register, and a held result stalls the next item at its
// result step. Memory reads as zero after reset through a valid bit per word, so no
// clearing pass is needed.
module decimal_accumulator_machine import dam_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	dam_in_if.sink in_ch,
	dam_out_if.source out_ch,
	dam_cfg_if.sink cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// config is always taken; the user must write only while idle, the block does not enforce it
	assign cfg.ready = 1'b1;

	dam_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_op(in_ch.op),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	dam_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_address(in_ch.address),
		.in_word(in_ch.word),
		.cfg_we(cfg.valid),
		.cfg_data(cfg.data),
		.sts(sts),
		.pc(out_ch.pc),
		.acc_value(out_ch.acc_value),
		.res_out_valid(out_ch.out_valid),
		.out_value(out_ch.out_value),
		.read_used(out_ch.read_used),
		.status(out_ch.status)
	);

endmodule

// ===== hw/rtl/dam_ctrl.sv =====
// Controller: sequences load, restart and instruction execution.
module dam_ctrl import dam_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_op,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dp_sts_t sts,
	output dp_cmd_t cmd
);

	cstate_t state_q, state_d;
	logic [1:0] op_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			op_q <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) op_q <= in_op;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == CS_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = (in_op == OP_EXEC) ? CS_FETCH : CS_EXEC;
				end
			end
			CS_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = CS_DECODE;
			end
			CS_DECODE: begin
				cmd.decode = 1'b1;
				state_d = sts.stop_pre ? CS_RESULT : CS_SPLIT;
			end
			CS_SPLIT: begin
				cmd.split = 1'b1;
				state_d = CS_OPERAND;
			end
			CS_OPERAND: begin
				cmd.operand = 1'b1;
				state_d = CS_EXEC;
			end
			CS_EXEC: begin
				if (op_q == OP_EXEC && sts.is_div) begin
					cmd.div_start = 1'b1;
					state_d = CS_DIV;
				end else begin
					if (op_q == OP_LOAD) cmd.mem_load = 1'b1;
					else if (op_q == OP_RESTART) cmd.restart = 1'b1;
					else if (op_q == OP_EXEC) cmd.exec = 1'b1;
					state_d = CS_RESULT;
				end
			end
			CS_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = CS_DIVFIX;
			end
			CS_DIVFIX: begin
				cmd.div_done = 1'b1;
				state_d = CS_RESULT;
			end
			CS_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.exec && !cmd.div_step)
		else $error("busy datapath while ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accept did not start work");
`endif

endmodule

// ===== hw/rtl/dam_dp.sv =====
// Datapath: memory, accumulator, counters, decoder and iterative divider.
module dam_dp import dam_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input logic [6:0] in_address,
	input logic [31:0] in_word,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	output dp_sts_t sts,
	output logic [6:0] pc,
	output logic [31:0] acc_value,
	output logic res_out_valid,
	output logic [31:0] out_value,
	output logic read_used,
	output logic [2:0] status
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [31:0] rd_q;
	logic rdv_q;
	logic [6:0] addr_q;
	logic [31:0] word_q;
	logic [6:0] pc_q;
	logic [31:0] acc_q;
	logic [15:0] steps_q, max_q;
	logic [2:0] st_q;
	logic [31:0] ir_q;
	logic [6:0] opc_q;
	logic [6:0] adr_q;
	logic [31:0] m_q;
	logic stop_q;
	// decode helpers
	logic [31:0] ir_abs;
	logic [25:0] q100;
	logic [31:0] r100;
	logic [31:0] prod;
	logic [6:0] opc_c, rem_c;
	logic [31:0] m_word;
	// divider
	logic [31:0] dq_q, dr_q, dd_q;
	logic [32:0] rem_q;
	logic [5:0] dcnt_q;
	logic dneg_q;
	logic [32:0] trial;
	logic [31:0] quot;
	// output regs
	logic [6:0] o_pc_q;
	logic [31:0] o_acc_q, o_val_q;
	logic o_ov_q, o_ru_q;
	logic [2:0] o_st_q;
	logic ov_q, ru_q;
	logic [31:0] ovl_q;

	// fetch address selection: the operand address comes straight from the split
	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = pc_q[AW-1:0];
		if (cmd.split) rd_addr = rem_c[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch || cmd.split) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.mem_load && addr_q < 7'(MEM_WORDS)) mem_q[addr_q[AW-1:0]] <= word_q;
		if (cmd.exec && !stop_q) begin
			if (opc_q == OPC_READ) mem_q[adr_q[AW-1:0]] <= word_q;
			else if (opc_q == OPC_STORE) mem_q[adr_q[AW-1:0]] <= acc_q;
		end
	end

	// valid bits give the all-zero reset of memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (cmd.fetch || cmd.split) rdv_q <= vld_q[rd_addr];
			if (cmd.mem_load && addr_q < 7'(MEM_WORDS)) vld_q[addr_q[AW-1:0]] <= 1'b1;
			if (cmd.exec && !stop_q && (opc_q == OPC_READ || opc_q == OPC_STORE))
				vld_q[adr_q[AW-1:0]] <= 1'b1;
		end
	end

	assign m_word = rdv_q ? rd_q : 32'd0;

	// opcode/address split by reciprocal multiply on |ir|
	assign ir_abs = ir_q[31] ? (~ir_q + 32'd1) : ir_q;
	always_comb begin
		logic [63:0] full;
		full = {32'd0, ir_abs} * 64'd2748779070;
		q100 = full[63:38];
		r100 = ir_abs - 32'(q100) * 32'd100;
		if (r100 >= 32'd100) begin
			q100 = q100 + 26'd1;
			r100 = r100 - 32'd100;
		end
		rem_c = r100[6:0];
		// a quotient above 99, or nonzero on a negative word, becomes opcode 0, a bad opcode
		opc_c = (ir_q[31] && q100 != 26'd0) || q100 > 26'd99 ? 7'd0 : q100[6:0];
	end

	assign prod = acc_q * m_q;

	// divider: unsigned restoring on magnitudes
	assign trial = {rem_q[31:0], dd_q[31]} - {1'b0, dr_q};
	assign quot = dneg_q ? (~dq_q + 32'd1) : dq_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			addr_q <= in_address;
			word_q <= in_word;
		end
		if (cmd.decode) ir_q <= m_word;
		if (cmd.split) begin
			opc_q <= opc_c;
			adr_q <= rem_c;
		end
		if (cmd.operand) m_q <= m_word;
		if (cmd.div_start) begin
			dd_q <= acc_q[31] ? (~acc_q + 32'd1) : acc_q;
			dr_q <= m_q[31] ? (~m_q + 32'd1) : m_q;
			dneg_q <= acc_q[31] ^ m_q[31];
			rem_q <= '0;
			dq_q <= '0;
		end
		if (cmd.div_step) begin
			if (!trial[32]) rem_q <= trial;
			else rem_q <= {rem_q[31:0], dd_q[31]};
			dq_q <= {dq_q[30:0], !trial[32]};
			dd_q <= {dd_q[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			acc_q <= '0;
			steps_q <= '0;
			st_q <= ST_RUN;
			max_q <= MAX_STEPS_RST;
			stop_q <= 1'b0;
			dcnt_q <= '0;
			ov_q <= 1'b0;
			ru_q <= 1'b0;
			ovl_q <= '0;
			o_pc_q <= '0;
			o_acc_q <= '0;
			o_val_q <= '0;
			o_ov_q <= 1'b0;
			o_ru_q <= 1'b0;
			o_st_q <= ST_RUN;
		end else begin
			if (cfg_we) max_q <= cfg_data;
			if (cmd.latch_in) begin
				ov_q <= 1'b0;
				ru_q <= 1'b0;
				ovl_q <= '0;
				stop_q <= 1'b0;
			end
			if (cmd.decode) begin
				if (st_q != ST_RUN) stop_q <= 1'b1;
				else if (steps_q >= max_q) begin
					st_q <= ST_LIMIT;
					stop_q <= 1'b1;
				end else if (pc_q >= 7'(MEM_WORDS)) begin
					pc_q <= 7'(MEM_WORDS);
					st_q <= ST_OVER;
					stop_q <= 1'b1;
				end else begin
					steps_q <= steps_q + 16'd1;
					pc_q <= pc_q + 7'd1;
				end
			end
			if (cmd.restart) begin
				pc_q <= '0;
				acc_q <= '0;
				steps_q <= '0;
				st_q <= ST_RUN;
			end
			if (cmd.exec) begin
				unique case (opc_q)
					OPC_READ: ru_q <= 1'b1;
					OPC_WRITE: begin
						ov_q <= 1'b1;
						ovl_q <= m_q;
					end
					OPC_LOAD: acc_q <= m_q;
					OPC_STORE: ;
					OPC_ADD: acc_q <= acc_q + m_q;
					OPC_SUB: acc_q <= acc_q - m_q;
					OPC_MUL: acc_q <= prod;
					OPC_BR: pc_q <= adr_q;
					OPC_BRNEG: if (acc_q[31]) pc_q <= adr_q;
					OPC_BRZERO: if (acc_q == 32'd0) pc_q <= adr_q;
					OPC_HALT: st_q <= ST_HALT;
					default: st_q <= ST_BADOP;
				endcase
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
				if (m_q == 32'd0) st_q <= ST_DIV0;
			end
			if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
			if (cmd.div_done && st_q == ST_RUN) acc_q <= quot;
			if (cmd.out_load) begin
				o_pc_q <= pc_q;
				o_acc_q <= acc_q;
				o_st_q <= st_q;
				o_ov_q <= ov_q && st_q == ST_RUN;
				o_val_q <= st_q == ST_RUN ? ovl_q : 32'd0;
				o_ru_q <= ru_q && st_q == ST_RUN;
			end
		end
	end

	assign sts.stop_pre = (st_q != ST_RUN) || (steps_q >= max_q) || (pc_q >= 7'(MEM_WORDS));
	assign sts.is_div = (opc_q == OPC_DIV);
	assign sts.div_last = (dcnt_q == 6'd31);

	assign pc = o_pc_q;
	assign acc_value = o_acc_q;
	assign res_out_valid = o_ov_q;
	assign out_value = o_val_q;
	assign read_used = o_ru_q;
	assign status = o_st_q;

`ifndef SYNTHESIS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= 7'(MEM_WORDS))
		else $error("pc out of range");
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		o_st_q != ST_RUN |-> !o_ov_q && !o_ru_q)
		else $error("stopped machine emitted");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> dcnt_q == 6'd0)
		else $error("divider count not cleared");
`endif

endmodule

// ===== dv/tb_decimal_accumulator_machine.sv =====
// Testbench for the decimal accumulator machine: program loading, execution and step limit.
module tb_decimal_accumulator_machine;
	import dam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Result fields the machine reports after each transfer.
	typedef struct packed {
		logic [6:0] pc;
		logic [31:0] acc_value;
		logic out_valid;
		logic [31:0] out_value;
		logic read_used;
		logic [2:0] status;
	} machine_view_t;

	logic clk;
	logic arst_n;

	dam_in_if in_ch();
	dam_out_if out_ch();
	dam_cfg_if cfg();

	decimal_accumulator_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// Model state: memory, counter, accumulator, step count, status, step limit.
	logic [31:0] model_mem [0:99];
	logic [6:0] model_pc;
	logic [31:0] model_acc;
	logic [15:0] model_steps;
	status_t model_status;
	logic [15:0] model_limit;

	machine_view_t expected_views [$];
	int fail_count;
	int idle_pct;
	int sink_hold;
	int quiet_cycles;
	bit run_done;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Apply one item to the model and queue the result it must produce.
	task automatic predict_item(input logic [1:0] op, input logic [6:0] addr,
			input logic [31:0] word);
		machine_view_t v;
		logic signed [31:0] ir;
		logic signed [31:0] opc;
		logic signed [31:0] rem;
		logic [6:0] adr;
		logic [31:0] m;
		logic signed [63:0] q;
		v = '0;
		case (op)
			OP_LOAD: begin
				if (addr < 7'd100)
					model_mem[addr] = word;
			end
			OP_RESTART: begin
				model_pc = '0;
				model_acc = '0;
				model_steps = '0;
				model_status = ST_RUN;
			end
			OP_EXEC: begin
				if (model_status != ST_RUN) begin
				end else if (model_steps >= model_limit) begin
					model_status = ST_LIMIT;
				end else if (model_pc >= 7'd100) begin
					model_pc = 7'd100;
					model_status = ST_OVER;
				end else begin
					model_steps = model_steps + 16'd1;
					ir = model_mem[model_pc];
					model_pc = model_pc + 7'd1;
					opc = ir / 100;
					rem = ir % 100;
					if (rem < 0)
						rem = -rem;
					adr = rem[6:0];
					m = model_mem[adr];
					case (opc)
						OPC_READ: begin
							model_mem[adr] = word;
							v.read_used = 1'b1;
						end
						OPC_WRITE: begin
							v.out_valid = 1'b1;
							v.out_value = m;
						end
						OPC_LOAD: model_acc = m;
						OPC_STORE: model_mem[adr] = model_acc;
						OPC_ADD: model_acc = model_acc + m;
						OPC_SUB: model_acc = model_acc - m;
						OPC_DIV: begin
							if (m == 0) begin
								model_status = ST_DIV0;
							end else begin
								q = $signed({{32{model_acc[31]}}, model_acc}) /
									$signed({{32{m[31]}}, m});
								model_acc = q[31:0];
							end
						end
						OPC_MUL: model_acc = model_acc * m;
						OPC_BR: model_pc = adr;
						OPC_BRNEG: begin
							if (model_acc[31])
								model_pc = adr;
						end
						OPC_BRZERO: begin
							if (model_acc == 0)
								model_pc = adr;
						end
						OPC_HALT: model_status = ST_HALT;
						default: model_status = ST_BADOP;
					endcase
					if (model_status != ST_RUN)
						v = '0;
				end
			end
			default: begin
			end
		endcase
		v.pc = model_pc;
		v.acc_value = model_acc;
		v.status = model_status;
		expected_views.push_back(v);
	endtask

	// Offer one item, idling at random first, and hold it until transfer.
	task automatic send_item(input logic [1:0] op, input logic [6:0] addr,
			input logic [31:0] word);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.address <= addr;
		in_ch.word <= word;
		predict_item(op, addr, word);
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Wait for all results, then write the step limit while the block is idle.
	task automatic write_limit(input logic [15:0] limit);
		in_ch.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= limit;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		model_limit = limit;
	endtask

	function automatic logic [31:0] instr(input int opc, input int adr);
		return opc * 100 + adr;
	endfunction

	// Load a program at address 0 then restart.
	task automatic load_program(input logic [31:0] prog [$]);
		foreach (prog[i])
			send_item(OP_LOAD, 7'(i), prog[i]);
		send_item(OP_RESTART, 7'($urandom), $urandom);
	endtask

	task automatic test_directed_ops();
		logic [31:0] prog [$];
		// Cover every opcode once plus a divide overflow and a write.
		prog = '{instr(OPC_READ, 90), instr(OPC_LOAD, 90), instr(OPC_DIV, 91),
			instr(OPC_WRITE, 90), instr(OPC_ADD, 91), instr(OPC_SUB, 92),
			instr(OPC_MUL, 92), instr(OPC_STORE, 93), instr(OPC_BRNEG, 10),
			instr(OPC_BRZERO, 10), instr(OPC_BR, 10)};
		load_program(prog);
		send_item(OP_LOAD, 91, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 92, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 10, instr(OPC_HALT, 0));
		send_item(OP_LOAD, 127, 32'h1234_5678);
		send_item(OP_EXEC, 0, 32'h8000_0000);
		repeat (12) send_item(OP_EXEC, 0, $urandom);
		send_item(OP_NONE, 7'h7F, 32'hFFFF_FFFF);
	endtask

	task automatic test_faults();
		// Divide by zero, a bad negative opcode, running past memory.
		send_item(OP_LOAD, 0, instr(OPC_DIV, 55));
		send_item(OP_LOAD, 55, 0);
		send_item(OP_RESTART, 0, 0);
		send_item(OP_EXEC, 0, 0);
		send_item(OP_EXEC, 0, 0);
		send_item(OP_LOAD, 0, -32'sd4405);
		send_item(OP_RESTART, 0, 0);
		send_item(OP_EXEC, 0, 0);
		send_item(OP_LOAD, 0, instr(OPC_BR, 99));
		send_item(OP_LOAD, 99, instr(OPC_ADD, 1));
		send_item(OP_RESTART, 0, 0);
		repeat (4) send_item(OP_EXEC, 0, 0);
	endtask

	task automatic test_step_limit();
		write_limit(16'd1);
		send_item(OP_LOAD, 0, instr(OPC_BR, 0));
		send_item(OP_RESTART, 0, 0);
		repeat (3) send_item(OP_EXEC, 0, 0);
		write_limit(16'd0);
		send_item(OP_RESTART, 0, 0);
		send_item(OP_EXEC, 0, 0);
		write_limit(16'hFFFF);
	endtask

	// Random programs of valid instructions, with some noise words.
	task automatic test_random_programs(input int items);
		int sent;
		int len;
		int k;
		logic [31:0] w;
		int opcodes [12] = '{10, 11, 20, 21, 30, 31, 32, 33, 40, 41, 42, 43};
		sent = 0;
		while (sent < items) begin
			len = $urandom_range(12, 2);
			for (k = 0; k < 100; k += $urandom_range(20, 1)) begin
				if ($urandom_range(9, 0) == 0)
					w = $urandom;
				else if (k < len)
					w = instr(opcodes[$urandom_range(11, 0)], $urandom_range(99, 0));
				else
					w = $urandom_range(3, 0) == 0 ? 32'd0 : $urandom;
				if (w[0] && $urandom_range(3, 0) == 0 && k < len)
					w = -$signed(w);
				send_item($urandom_range(19, 0) == 0 ? OP_NONE : OP_LOAD,
					7'($urandom_range(3, 0) == 0 ? $urandom : k), w);
				sent++;
			end
			send_item(OP_RESTART, 7'($urandom), $urandom);
			repeat ($urandom_range(30, 5)) begin
				send_item($urandom_range(15, 0) == 0 ? OP_LOAD : OP_EXEC,
					7'($urandom_range(99, 0)), $urandom);
				sent++;
			end
		end
	endtask

	// Receiver: stall at random, and once hold off for a long stretch.
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= $urandom_range(99, 0) >= idle_pct;
		end
	end

	// Compare each transferred result against the oldest prediction.
	always @(posedge clk) begin
		machine_view_t exp_v;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_views.size() == 0) begin
				$error("result with no prediction pending");
				fail_count++;
			end else begin
				exp_v = expected_views.pop_front();
				if (out_ch.pc !== exp_v.pc) begin
					$error("pc exp %0d got %0d", exp_v.pc, out_ch.pc);
					fail_count++;
				end
				if (out_ch.acc_value !== exp_v.acc_value) begin
					$error("acc_value exp %0h got %0h", exp_v.acc_value, out_ch.acc_value);
					fail_count++;
				end
				if (out_ch.out_valid !== exp_v.out_valid) begin
					$error("out_valid exp %0d got %0d", exp_v.out_valid, out_ch.out_valid);
					fail_count++;
				end
				if (out_ch.out_value !== exp_v.out_value) begin
					$error("out_value exp %0h got %0h", exp_v.out_value, out_ch.out_value);
					fail_count++;
				end
				if (out_ch.read_used !== exp_v.read_used) begin
					$error("read_used exp %0d got %0d", exp_v.read_used, out_ch.read_used);
					fail_count++;
				end
				if (out_ch.status !== exp_v.status) begin
					$error("status exp %0d got %0d", exp_v.status, out_ch.status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || run_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("tb_decimal_accumulator_machine NOT OK");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_NONE;
		in_ch.address = '0;
		in_ch.word = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		fail_count = 0;
		idle_pct = 29;
		sink_hold = 0;
		quiet_cycles = 0;
		run_done = 1'b0;
		foreach (model_mem[i])
			model_mem[i] = '0;
		model_pc = '0;
		model_acc = '0;
		model_steps = '0;
		model_status = ST_RUN;
		model_limit = MAX_STEPS_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_faults();
		test_step_limit();
		// Stall the receiver long enough for the input to back up.
		sink_hold = 300;
		test_random_programs(100);
		// Run without any idling for a while.
		idle_pct = 0;
		test_random_programs(300);
		idle_pct = 29;
		write_limit(16'd20);
		test_random_programs(500);
		write_limit(MAX_STEPS_RST);
		test_random_programs(500);
		in_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (expected_views.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		run_done = 1'b1;
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_views.size() == 0)
			$display("tb_decimal_accumulator_machine OK");
		else
			$display("tb_decimal_accumulator_machine NOT OK");
		$finish;
	end
endmodule
